[src/u2a_pkg.sv]
// shared types, constants and the code point mapping function
package u2a_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       run_last;
   } rsp_type;

   localparam int unsigned MaxChars = 4;
   localparam logic [6:0] CharQ     = 7'h3F;
   localparam logic [6:0] CharSpace = 7'h20;

   // replacement text of a code point: count and up to three characters
   typedef struct packed {
      logic [1:0] cnt;
      logic [6:0] c0;
      logic [6:0] c1;
      logic [6:0] c2;
   } xlat_type;

   function automatic xlat_type mk(input logic [1:0] cnt, input logic [7:0] a,
                                   input logic [7:0] b, input logic [7:0] c);
      xlat_type r;
      r.cnt = cnt;
      r.c0  = a[6:0];
      r.c1  = b[6:0];
      r.c2  = c[6:0];
      return r;
   endfunction

   function automatic xlat_type one(input logic [7:0] a);
      return mk(2'd1, a, 8'h00, 8'h00);
   endfunction

   // table hit for a code point, valid flag in hit
   function automatic xlat_type xlat_lookup(input logic [20:0] cp, output logic hit);
      xlat_type r;
      r   = '0;
      hit = 1'b1;
      unique case (cp)
         21'h80: r = mk(2'd3, "E", "U", "R");
         21'h85: r = mk(2'd3, ".", ".", ".");
         21'h91, 21'h92: r = one("'");
         21'h93, 21'h94: r = one("\"");
         21'h96, 21'h97: r = one("-");
         21'hA1: r = one("!");
         21'hA2: r = one("c");
         21'hA3: r = mk(2'd3, "G", "B", "P");
         21'hA5: r = mk(2'd3, "J", "P", "Y");
         21'hA7: r = one("S");
         21'hA9: r = mk(2'd3, "(", "c", ")");
         21'hAB: r = one("\"");
         21'hAE: r = mk(2'd3, "(", "R", ")");
         21'hB0: r = '0;
         21'hB1: r = mk(2'd3, "+", "/", "-");
         21'hB7: r = one("*");
         21'hBB: r = one("\"");
         21'hBC: r = mk(2'd3, "1", "/", "4");
         21'hBD: r = mk(2'd3, "1", "/", "2");
         21'hBE: r = mk(2'd3, "3", "/", "4");
         21'hBF: r = one("?");
         21'hC0, 21'hC1, 21'hC2, 21'hC3, 21'hC5: r = one("A");
         21'hC4: r = mk(2'd2, "A", "e", 8'h00);
         21'hC6: r = mk(2'd2, "A", "E", 8'h00);
         21'hC7: r = one("C");
         21'hC8, 21'hC9, 21'hCA, 21'hCB: r = one("E");
         21'hCC, 21'hCD, 21'hCE, 21'hCF: r = one("I");
         21'hD0: r = one("D");
         21'hD1: r = one("N");
         21'hD2, 21'hD3, 21'hD4, 21'hD5, 21'hD8: r = one("O");
         21'hD6: r = mk(2'd2, "O", "e", 8'h00);
         21'hD7: r = one("x");
         21'hD9, 21'hDA, 21'hDB: r = one("U");
         21'hDC: r = mk(2'd2, "U", "e", 8'h00);
         21'hDD: r = one("Y");
         21'hDE: r = mk(2'd2, "T", "h", 8'h00);
         21'hDF: r = mk(2'd2, "s", "s", 8'h00);
         21'hE0, 21'hE1, 21'hE2, 21'hE3, 21'hE5: r = one("a");
         21'hE4, 21'hE6: r = mk(2'd2, "a", "e", 8'h00);
         21'hE7: r = one("c");
         21'hE8, 21'hE9, 21'hEA, 21'hEB: r = one("e");
         21'hEC, 21'hED, 21'hEE, 21'hEF: r = one("i");
         21'hF0: r = one("d");
         21'hF1: r = one("n");
         21'hF2, 21'hF3, 21'hF4, 21'hF5, 21'hF8: r = one("o");
         21'hF6: r = mk(2'd2, "o", "e", 8'h00);
         21'hF7: r = one("/");
         21'hF9, 21'hFA, 21'hFB: r = one("u");
         21'hFC: r = mk(2'd2, "u", "e", 8'h00);
         21'hFD, 21'hFF: r = one("y");
         21'hFE: r = mk(2'd2, "t", "h", 8'h00);
         21'h100, 21'h104: r = one("A");
         21'h101, 21'h105: r = one("a");
         21'h106, 21'h10C: r = one("C");
         21'h107, 21'h10D: r = one("c");
         21'h10E: r = one("D");
         21'h10F: r = one("d");
         21'h118, 21'h11A: r = one("E");
         21'h119, 21'h11B: r = one("e");
         21'h11E: r = one("G");
         21'h11F: r = one("g");
         21'h130: r = one("I");
         21'h131: r = one("i");
         21'h141: r = one("L");
         21'h142: r = one("l");
         21'h143, 21'h147: r = one("N");
         21'h144, 21'h148: r = one("n");
         21'h152: r = mk(2'd2, "O", "E", 8'h00);
         21'h153: r = mk(2'd2, "o", "e", 8'h00);
         21'h158: r = one("R");
         21'h159: r = one("r");
         21'h15A, 21'h15E, 21'h160: r = one("S");
         21'h15B, 21'h15F, 21'h161: r = one("s");
         21'h164: r = one("T");
         21'h165: r = one("t");
         21'h16E: r = one("U");
         21'h16F: r = one("u");
         21'h178: r = one("Y");
         21'h179, 21'h17B, 21'h17D: r = one("Z");
         21'h17A, 21'h17C, 21'h17E: r = one("z");
         21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2015, 21'h2212:
            r = one("-");
         21'h2018, 21'h2019, 21'h201B, 21'h2032: r = one("'");
         21'h201A: r = one(",");
         21'h201C, 21'h201D, 21'h201E, 21'h201F, 21'h2033: r = one("\"");
         21'h2022, 21'h2023, 21'h25CF: r = one("*");
         21'h2026: r = mk(2'd3, ".", ".", ".");
         21'h2039: r = one("<");
         21'h203A: r = one(">");
         21'h20AC: r = mk(2'd3, "E", "U", "R");
         21'h2122: r = mk(2'd2, "T", "M", 8'h00);
         21'h2190: r = mk(2'd2, "<", "-", 8'h00);
         21'h2192: r = mk(2'd2, "-", ">", 8'h00);
         21'h2264: r = mk(2'd2, "<", "=", 8'h00);
         21'h2265: r = mk(2'd2, ">", "=", 8'h00);
         21'h2248: r = one("~");
         default: hit = 1'b0;
      endcase
      return r;
   endfunction

   // full mapping of a finished code point
   function automatic xlat_type map_point(input logic [20:0] cp);
      xlat_type r;
      logic     hit;
      xlat_type t;
      t = xlat_lookup(cp, hit);
      if (cp >= 21'h20 && cp < 21'h7F) begin
         r = one({1'b0, cp[6:0]});
      end else if (cp == 21'h0A) begin
         r = one(8'h0A);
      end else if (cp < 21'h20 || cp == 21'h7F || cp == 21'hA0 ||
                   (cp >= 21'h2000 && cp <= 21'h200A)) begin
         r = one({1'b0, CharSpace});
      end else if (hit) begin
         r = t;
      end else if ((cp >= 21'h200B && cp <= 21'h200F) || cp == 21'hAD || cp == 21'hFEFF ||
                   (cp >= 21'hFE00 && cp <= 21'hFE0F) || (cp >= 21'h2028 && cp <= 21'h202E) ||
                   cp >= 21'h1F000 || (cp >= 21'h2600 && cp <= 21'h27BF)) begin
         r = '0;
      end else begin
         r = one({1'b0, CharQ});
      end
      return r;
   endfunction

endpackage

[src/u2a_decode.sv]
// decoder step: next sequence state and the characters one byte causes
module u2a_decode import u2a_pkg::*; (
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   input  logic [20:0] point,
   input  logic [1:0]  needed,
   input  logic [1:0]  buffered,
   output logic [20:0] point_next,
   output logic [1:0]  needed_next,
   output logic [1:0]  buffered_next,
   output logic [2:0]  char_cnt,
   output logic [6:0]  chars [MaxChars]
);

   logic [2:0]  n;
   logic [20:0] pp;
   logic [1:0]  nd;
   logic [1:0]  bb;
   xlat_type    mp;
   logic        is_cont;
   logic [20:0] acc;

   always_comb begin
      for (int i = 0; i < MaxChars; i++) chars[i] = CharQ;
      n       = 3'd0;
      pp      = point;
      nd      = needed;
      bb      = buffered;
      is_cont = (in_byte[7:6] == 2'b10);
      acc     = {point[14:0], in_byte[5:0]};
      mp      = map_point(acc);
      if (needed != 2'd0 && is_cont) begin
         pp = acc;
         bb = buffered + 2'd1;
         nd = needed - 2'd1;
         if (nd == 2'd0) begin
            n  = {1'b0, mp.cnt};
            chars[0] = mp.c0;
            chars[1] = mp.c1;
            chars[2] = mp.c2;
            pp = '0;
            bb = '0;
         end
      end else begin
         if (needed != 2'd0) begin
            // bad continuation: one '?' for the lead and each buffered byte
            n  = {1'b0, buffered} + 3'd1;
            pp = '0;
            nd = '0;
         end
         bb = '0;
         mp = map_point({13'd0, in_byte});
         if (!in_byte[7]) begin
            if (mp.cnt != 2'd0) begin
               chars[n[1:0]] = mp.c0;
               n = n + 3'd1;
            end
         end else if (in_byte[7:5] == 3'b110) begin
            nd = 2'd1;
            pp = {16'd0, in_byte[4:0]};
         end else if (in_byte[7:4] == 4'b1110) begin
            nd = 2'd2;
            pp = {17'd0, in_byte[3:0]};
         end else if (in_byte[7:3] == 5'b11110) begin
            nd = 2'd3;
            pp = {18'd0, in_byte[2:0]};
         end else begin
            n = n + 3'd1;
         end
      end
      if (in_last && nd != 2'd0) begin
         // remaining slots already hold '?'
         n  = n + {1'b0, bb} + 3'd1;
         pp = '0;
         nd = '0;
         bb = '0;
      end
      if (n > 3'd4) n = 3'd4;
      point_next    = pp;
      needed_next   = nd;
      buffered_next = bb;
      char_cnt      = n;
   end

endmodule

[src/utf8_to_ascii_transliterator.sv]
// top level: utf-8 byte stream in, ascii characters out
//
// req channel: one utf-8 byte per item with a last flag closing the text
// rsp channel: ascii characters, run_last set on the last one a byte causes
// a byte is decoded in the cycle it is accepted; its characters (0 to 4)
// are written into a four-entry result buffer and leave one per cycle
// while rsp_ready is high, from the next cycle on
// throughput: one byte per cycle while rsp_ready is high and each byte
// yields at most one character; more characters hold req_ready low until
// the last is taken; bytes yielding nothing give no output, never stall
// req_ready is high whenever the buffer is empty or drains this cycle,
// so a waiting character never blocks the next byte's acceptance then
// when the receiver stalls, characters stay in the buffer and req_ready
// drops until the last buffered one is taken
// reset (synchronous, active high) closes any open sequence and empties
// the buffer
module utf8_to_ascii_transliterator import u2a_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // decoder state
   logic [20:0] point_ff, point_in;
   logic [1:0]  needed_ff, needed_in;
   logic [1:0]  buffered_ff, buffered_in;

   // result buffer: characters and count of those left, index of next
   logic [6:0]  buf_ff [MaxChars];
   logic [6:0]  buf_in [MaxChars];
   logic [2:0]  left_ff, left_in;
   logic [1:0]  pos_ff, pos_in;

   logic [2:0]  char_cnt;
   logic [6:0]  chars [MaxChars];
   logic [20:0] dec_point;
   logic [1:0]  dec_needed, dec_buffered;
   logic        req_fire, rsp_fire;

   u2a_decode u_decode (
      .in_byte      (req_data.in_byte),
      .in_last      (req_data.in_last),
      .point        (point_ff),
      .needed       (needed_ff),
      .buffered     (buffered_ff),
      .point_next   (dec_point),
      .needed_next  (dec_needed),
      .buffered_next(dec_buffered),
      .char_cnt     (char_cnt),
      .chars        (chars)
   );

   assign rsp_valid         = (left_ff != 3'd0);
   assign rsp_data.out_char = buf_ff[pos_ff];
   assign rsp_data.run_last = (left_ff == 3'd1);
   assign rsp_fire          = rsp_valid && rsp_ready;
   // free once the last waiting character leaves
   assign req_ready         = (left_ff == 3'd0) || (left_ff == 3'd1 && rsp_ready);
   assign req_fire          = req_valid && req_ready;

   always_comb begin
      point_in    = point_ff;
      needed_in   = needed_ff;
      buffered_in = buffered_ff;
      buf_in      = buf_ff;
      left_in     = left_ff;
      pos_in      = pos_ff;
      if (rsp_fire) begin
         left_in = left_ff - 3'd1;
         pos_in  = pos_ff + 2'd1;
      end
      if (req_fire) begin
         point_in    = dec_point;
         needed_in   = dec_needed;
         buffered_in = dec_buffered;
         buf_in      = chars;
         left_in     = char_cnt;
         pos_in      = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff    <= '0;
         needed_ff   <= '0;
         buffered_ff <= '0;
         left_ff     <= '0;
         pos_ff      <= '0;
      end else begin
         point_ff    <= point_in;
         needed_ff   <= needed_in;
         buffered_ff <= buffered_in;
         left_ff     <= left_in;
         pos_ff      <= pos_in;
      end
      buf_ff <= buf_in;
   end

   // buffer never holds more than four characters
   assert property (@(posedge clock) disable iff (reset) left_ff <= 3'd4)
      else $error("result count overflow");

   // a last byte always leaves no sequence open
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.in_last |=> needed_ff == 2'd0)
      else $error("sequence open after last byte");

   // no buffered bytes are counted while no sequence is open
   assert property (@(posedge clock) disable iff (reset)
      needed_ff == 2'd0 |-> buffered_ff == 2'd0)
      else $error("buffered bytes with no open sequence");

endmodule
